[design/blps_pkg.sv]
// Package for the bicolor LED pattern sequencer.
// Holds pattern codes, timer constants and field widths; no dependencies.
package blps_pkg;

  // field widths
  localparam int PatternWidth = 4;
  localparam int HoldWidth    = 7;
  localparam int TimerWidth   = 8;

  // pattern codes
  localparam logic [PatternWidth-1:0] PAT_OFF         = 4'd0;
  localparam logic [PatternWidth-1:0] PAT_GREEN       = 4'd1;
  localparam logic [PatternWidth-1:0] PAT_RED         = 4'd2;
  localparam logic [PatternWidth-1:0] PAT_AMBER       = 4'd3;
  localparam logic [PatternWidth-1:0] PAT_GREEN_BLINK = 4'd4;
  localparam logic [PatternWidth-1:0] PAT_AMBER_BLINK = 4'd5;
  localparam logic [PatternWidth-1:0] PAT_AMBER_FAST  = 4'd6;
  localparam logic [PatternWidth-1:0] PAT_RED_FAST    = 4'd7;
  localparam logic [PatternWidth-1:0] PAT_RED_BLINK   = 4'd8;
  localparam logic [PatternWidth-1:0] PAT_GREEN_FLASH = 4'd9;
  localparam logic [PatternWidth-1:0] PAT_AMBER_FLASH = 4'd10;
  localparam logic [PatternWidth-1:0] PAT_RED_FLASH   = 4'd11;

  // input mode codes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // slow hold after reset, fast hold, last flash count before auto-off
  localparam logic [HoldWidth-1:0] SLOW_HOLD_RESET = 7'd3;
  localparam logic [HoldWidth-1:0] FAST_HOLD       = 7'd0;
  localparam logic [HoldWidth-1:0] FLASH_LAST      = 7'd6;

  // one result item
  typedef struct packed {
    logic                    red_on;
    logic                    green_on;
    logic [PatternWidth-1:0] pattern_now;
  } result_t;

endpackage

[design/bicolor_led_pattern_sequencer.sv]
// Top level of the bicolor LED pattern sequencer: state update, result
// register and skid stage. Depends on blps_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, mode, pattern          | input item
//  out     | out_valid, out_ready, red_on, green_on,   | result item
//          |   pattern_now                              |
//  cfg     | cfg_valid, cfg_ready, cfg_data (slow_hold) | register write
//
// One item per clock while in_ready is high: the state update is a single
// combinational pass whose result is registered at the input transfer.
// While a result is stalled, the next one goes into a one-entry skid stage, so
// one more item is taken; in_ready drops only while the skid stage is full.
// rst is synchronous, active high: timer, pattern and LEDs cleared,
// slow_hold back to 3, both output stages empty. cfg_ready is always high.
module bicolor_led_pattern_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [blps_pkg::PatternWidth-1:0] pattern,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             red_on,
  output logic                             green_on,
  output logic [blps_pkg::PatternWidth-1:0] pattern_now,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blps_pkg::HoldWidth-1:0]   cfg_data
);

  // sequencer state
  logic [blps_pkg::HoldWidth-1:0]    slow_hold;
  logic [blps_pkg::TimerWidth-1:0]   phase_timer, phase_timer_next;
  logic [blps_pkg::PatternWidth-1:0] current_pattern, current_pattern_next;
  logic                              red_level, red_level_next;
  logic                              green_level, green_level_next;

  // output stages
  blps_pkg::result_t out_data, skid_data, result;
  logic              skid_valid;

  // blink helper signals
  logic [blps_pkg::HoldWidth-1:0]  blink_hold;
  logic [blps_pkg::HoldWidth-1:0]  count;
  logic [blps_pkg::TimerWidth-1:0] blink_timer;
  logic                            blink_phase;

  logic in_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;

  // blink timer advance: count up to the hold, then flip the phase
  assign count = phase_timer[blps_pkg::HoldWidth-1:0];
  always_comb begin
    case (current_pattern)
      blps_pkg::PAT_AMBER_FAST,
      blps_pkg::PAT_RED_FAST: blink_hold = blps_pkg::FAST_HOLD;
      default:                blink_hold = slow_hold;
    endcase
    if (count < blink_hold) begin
      blink_timer = {phase_timer[blps_pkg::TimerWidth-1],
                     count + blps_pkg::HoldWidth'(1)};
    end else begin
      blink_timer = {!phase_timer[blps_pkg::TimerWidth-1], {blps_pkg::HoldWidth{1'b0}}};
    end
    blink_phase = blink_timer[blps_pkg::TimerWidth-1];
  end

  // next state for one item
  always_comb begin
    phase_timer_next     = phase_timer;
    current_pattern_next = current_pattern;
    red_level_next       = red_level;
    green_level_next     = green_level;
    if (mode == blps_pkg::MODE_WRITE) begin
      current_pattern_next = pattern;
    end else begin
      case (current_pattern)
        blps_pkg::PAT_OFF: begin
          red_level_next   = 1'b0;
          green_level_next = 1'b0;
          phase_timer_next = '0;
        end
        blps_pkg::PAT_GREEN: begin
          red_level_next   = 1'b0;
          green_level_next = 1'b1;
        end
        blps_pkg::PAT_RED: begin
          red_level_next   = 1'b1;
          green_level_next = 1'b0;
        end
        blps_pkg::PAT_AMBER: begin
          red_level_next   = 1'b1;
          green_level_next = 1'b1;
        end
        blps_pkg::PAT_GREEN_BLINK: begin
          phase_timer_next = blink_timer;
          red_level_next   = 1'b0;
          green_level_next = blink_phase;
        end
        blps_pkg::PAT_AMBER_BLINK,
        blps_pkg::PAT_AMBER_FAST: begin
          phase_timer_next = blink_timer;
          red_level_next   = blink_phase;
          green_level_next = blink_phase;
        end
        blps_pkg::PAT_RED_FAST,
        blps_pkg::PAT_RED_BLINK: begin
          phase_timer_next = blink_timer;
          red_level_next   = blink_phase;
          green_level_next = 1'b0;
        end
        blps_pkg::PAT_GREEN_FLASH,
        blps_pkg::PAT_AMBER_FLASH,
        blps_pkg::PAT_RED_FLASH: begin
          // phase bit dropped; count runs to seven, then back to off
          if (count > blps_pkg::FLASH_LAST) begin
            phase_timer_next     = {1'b0, count};
            current_pattern_next = blps_pkg::PAT_OFF;
          end else begin
            phase_timer_next = {1'b0, count + blps_pkg::HoldWidth'(1)};
            if (count[0]) begin
              red_level_next   = (current_pattern != blps_pkg::PAT_GREEN_FLASH);
              green_level_next = (current_pattern != blps_pkg::PAT_RED_FLASH);
            end else begin
              red_level_next   = 1'b0;
              green_level_next = 1'b0;
            end
          end
        end
        default: begin
          // undefined patterns hold everything
        end
      endcase
    end
  end

  assign result.red_on      = red_level_next;
  assign result.green_on    = green_level_next;
  assign result.pattern_now = current_pattern_next;

  // state registers and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_hold       <= blps_pkg::SLOW_HOLD_RESET;
      phase_timer     <= '0;
      current_pattern <= blps_pkg::PAT_OFF;
      red_level       <= 1'b0;
      green_level     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slow_hold <= cfg_data;
      end
      if (in_xfer) begin
        phase_timer     <= phase_timer_next;
        current_pattern <= current_pattern_next;
        red_level       <= red_level_next;
        green_level     <= green_level_next;
      end
    end
  end

  // output stage control: skid drains first, a new result goes to the
  // result register when it frees up, else into the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_ready) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign red_on      = out_data.red_on;
  assign green_on    = out_data.green_on;
  assign pattern_now = out_data.pattern_now;

endmodule

[design/blps_checker.sv]
// Port-level checks for the bicolor LED pattern sequencer, bound to the top.
// Depends on blps_pkg and bicolor_led_pattern_sequencer.
module blps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              mode,
  input logic [blps_pkg::PatternWidth-1:0] pattern,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              red_on,
  input logic                              green_on,
  input logic [blps_pkg::PatternWidth-1:0] pattern_now,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_on) && $stable(green_on)
      && $stable(pattern_now))
    else $error("stalled result changed");

  // input back-pressure only while a result is pending
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  // a pattern write with a free result register shows up next cycle
  a_write_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == blps_pkg::MODE_WRITE && (!out_valid || out_ready)
      |=> out_valid && pattern_now == $past(pattern))
    else $error("pattern write not reported");

  // a config write is never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bicolor_led_pattern_sequencer blps_checker u_blps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .mode       (mode),
  .pattern    (pattern),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .red_on     (red_on),
  .green_on   (green_on),
  .pattern_now(pattern_now),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

[verif/tb.sv]
// Testbench for bicolor_led_pattern_sequencer: directed and random pattern/tick
// traffic, slow_hold reconfiguration, scoreboard against an in-bench LED model.
// Depends on blps_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [blps_pkg::TimerWidth-1:0] PHASE_BIT = 8'h80;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // block inputs, known from time zero
  logic                              in_valid  = 1'b0;
  logic                              mode      = blps_pkg::MODE_TICK;
  logic [blps_pkg::PatternWidth-1:0] pattern   = blps_pkg::PAT_OFF;
  logic                              out_ready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic [blps_pkg::HoldWidth-1:0]    cfg_data  = '0;

  logic                              in_ready;
  logic                              out_valid;
  logic                              red_on;
  logic                              green_on;
  logic [blps_pkg::PatternWidth-1:0] pattern_now;
  logic                              cfg_ready;

  bicolor_led_pattern_sequencer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .pattern     (pattern),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_on      (red_on),
    .green_on    (green_on),
    .pattern_now (pattern_now),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // LED model state
  logic [blps_pkg::TimerWidth-1:0]   led_timer     = '0;
  logic [blps_pkg::PatternWidth-1:0] led_pattern   = blps_pkg::PAT_OFF;
  logic                              red_lvl       = 1'b0;
  logic                              green_lvl     = 1'b0;
  logic [blps_pkg::HoldWidth-1:0]    slow_hold_cfg = blps_pkg::SLOW_HOLD_RESET;

  blps_pkg::result_t led_expect_q[$];
  blps_pkg::result_t led_want;
  int                fail_count = 0;
  int                burst_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Step the blink timer with a given hold; returns the new phase bit
  function automatic logic advance_phase(input logic [blps_pkg::HoldWidth-1:0] hold);
    logic [blps_pkg::HoldWidth-1:0] count;
    count = led_timer[blps_pkg::HoldWidth-1:0];
    if (count < hold) begin
      led_timer = {led_timer[blps_pkg::TimerWidth-1], count + 7'd1};
    end else begin
      led_timer = led_timer[blps_pkg::TimerWidth-1] ? '0 : PHASE_BIT;
    end
    return led_timer[blps_pkg::TimerWidth-1];
  endfunction

  // Apply one accepted item to the model and queue the expected LEDs
  function automatic void led_predict(input logic m,
                                      input logic [blps_pkg::PatternWidth-1:0] p);
    logic                           ph;
    logic [blps_pkg::HoldWidth-1:0] flash_count;
    blps_pkg::result_t              res;
    if (m == blps_pkg::MODE_WRITE) begin
      led_pattern = p;
    end else begin
      case (led_pattern)
        blps_pkg::PAT_OFF: begin
          red_lvl = 1'b0; green_lvl = 1'b0; led_timer = '0;
        end
        blps_pkg::PAT_GREEN: begin
          red_lvl = 1'b0; green_lvl = 1'b1;
        end
        blps_pkg::PAT_RED: begin
          red_lvl = 1'b1; green_lvl = 1'b0;
        end
        blps_pkg::PAT_AMBER: begin
          red_lvl = 1'b1; green_lvl = 1'b1;
        end
        blps_pkg::PAT_GREEN_BLINK: begin
          red_lvl   = 1'b0;
          green_lvl = advance_phase(slow_hold_cfg);
        end
        blps_pkg::PAT_AMBER_BLINK, blps_pkg::PAT_AMBER_FAST: begin
          ph = advance_phase(led_pattern == blps_pkg::PAT_AMBER_BLINK ?
                             slow_hold_cfg : blps_pkg::FAST_HOLD);
          red_lvl = ph; green_lvl = ph;
        end
        blps_pkg::PAT_RED_FAST, blps_pkg::PAT_RED_BLINK: begin
          green_lvl = 1'b0;
          red_lvl   = advance_phase(led_pattern == blps_pkg::PAT_RED_BLINK ?
                                    slow_hold_cfg : blps_pkg::FAST_HOLD);
        end
        blps_pkg::PAT_GREEN_FLASH, blps_pkg::PAT_AMBER_FLASH, blps_pkg::PAT_RED_FLASH: begin
          // flashes run on the count alone; after the last one, back to off
          led_timer[blps_pkg::TimerWidth-1] = 1'b0;
          flash_count = led_timer[blps_pkg::HoldWidth-1:0];
          if (flash_count > blps_pkg::FLASH_LAST) begin
            led_pattern = blps_pkg::PAT_OFF;
          end else begin
            led_timer = led_timer + 8'd1;
            if (flash_count[0]) begin
              red_lvl   = (led_pattern != blps_pkg::PAT_GREEN_FLASH);
              green_lvl = (led_pattern != blps_pkg::PAT_RED_FLASH);
            end else begin
              red_lvl = 1'b0; green_lvl = 1'b0;
            end
          end
        end
        default: begin
          // undefined codes hold everything
        end
      endcase
    end
    res.red_on      = red_lvl;
    res.green_on    = green_lvl;
    res.pattern_now = led_pattern;
    led_expect_q.push_back(res);
  endfunction

  // Scoreboard: check results, track config writes, predict accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch("unexpected result transfer", int'(pattern_now), 0);
        end else begin
          led_want = led_expect_q.pop_front();
          if (red_on !== led_want.red_on)
            report_mismatch("red_on", int'(red_on), int'(led_want.red_on));
          if (green_on !== led_want.green_on)
            report_mismatch("green_on", int'(green_on), int'(led_want.green_on));
          if (pattern_now !== led_want.pattern_now)
            report_mismatch("pattern_now", int'(pattern_now),
                            int'(led_want.pattern_now));
        end
      end
      if (cfg_valid && cfg_ready) slow_hold_cfg = cfg_data;
      if (in_valid && in_ready) led_predict(mode, pattern);
    end
  end

  // Receiver back-pressure in one of four randomly chosen styles
  int stall_style = 0;
  int stall_left  = 0;
  int stall_phase = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 80);
    end
    stall_left--;
    stall_phase++;
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_phase % 7) >= 3);
    endcase
  end

  // Send one item; bursts of random length separated by random gaps
  task automatic send_item(input logic m, input logic [blps_pkg::PatternWidth-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    pattern  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slow_hold(input logic [blps_pkg::HoldWidth-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random writes, each followed by a run of ticks with junk pattern fields
  task automatic run_pattern_mix(input int n_items);
    int                                sent;
    int                                ticks;
    logic [blps_pkg::PatternWidth-1:0] pat;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 8) pat = blps_pkg::PatternWidth'($urandom_range(12, 15));
      else pat = blps_pkg::PatternWidth'($urandom_range(0, 11));
      send_item(blps_pkg::MODE_WRITE, pat);
      sent++;
      if (pat >= blps_pkg::PAT_GREEN_FLASH && pat <= blps_pkg::PAT_RED_FLASH)
        ticks = $urandom_range(3, 12);
      else ticks = $urandom_range(0, 10);
      repeat (ticks)
        send_item(blps_pkg::MODE_TICK, blps_pkg::PatternWidth'($urandom_range(0, 15)));
      sent += ticks;
    end
  endtask

  // Directed: reset hold, every pattern but red flash, ignored field, auto-off, undefined code
  task automatic test_directed();
    send_item(blps_pkg::MODE_TICK, 4'hF);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_GREEN);
    send_item(blps_pkg::MODE_TICK, blps_pkg::PAT_RED);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_RED);
    send_item(blps_pkg::MODE_TICK, 4'h0);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_AMBER);
    send_item(blps_pkg::MODE_TICK, 4'h5);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_GREEN_BLINK);
    repeat (5) send_item(blps_pkg::MODE_TICK, 4'hA);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_AMBER_FAST);
    send_item(blps_pkg::MODE_TICK, 4'h3);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_RED_FAST);
    send_item(blps_pkg::MODE_TICK, 4'hC);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_AMBER_BLINK);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_RED_BLINK);
    send_item(blps_pkg::MODE_TICK, 4'h9);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_AMBER_FLASH);
    repeat (9) send_item(blps_pkg::MODE_TICK, 4'h6);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_GREEN_FLASH);
    send_item(blps_pkg::MODE_WRITE, 4'hF);
    send_item(blps_pkg::MODE_TICK, 4'hF);
  endtask

  // Fast hold everywhere: slow patterns toggle every tick
  task automatic test_zero_hold();
    write_slow_hold(7'd0);
    run_pattern_mix(100);
  endtask

  // Largest hold: a red blink long enough to flip its slow phase, then a red flash
  task automatic test_max_hold();
    write_slow_hold(7'h7F);
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_RED_BLINK);
    repeat (132)
      send_item(blps_pkg::MODE_TICK, blps_pkg::PatternWidth'($urandom_range(0, 15)));
    send_item(blps_pkg::MODE_WRITE, blps_pkg::PAT_RED_FLASH);
    send_item(blps_pkg::MODE_TICK, 4'h0);
    run_pattern_mix(40);
  endtask

  task automatic test_random_hold();
    write_slow_hold(blps_pkg::HoldWidth'($urandom_range(1, 126)));
    run_pattern_mix(90);
  endtask

  task automatic test_default_hold();
    write_slow_hold(blps_pkg::SLOW_HOLD_RESET);
    run_pattern_mix(50);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_hold();
    test_max_hold();
    test_random_hold();
    test_default_hold();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

[bicolor_led_pattern_sequencer.f]
design/blps_pkg.sv
design/bicolor_led_pattern_sequencer.sv
design/blps_checker.sv
verif/tb.sv
